// File: rtl/cttok_pkg.sv
// ----------------------------------------------------------------------------
// cttok_pkg: shared types and constants of the command text tokenizer
// Scan modes, record and token codes, error codes and character constants.
// ----------------------------------------------------------------------------
package cttok_pkg;

  // default counter width (line, column, length)
  localparam int CNT_BITS_DEF = 16;

  // output field width of line, column and length
  localparam int FIELD_W = 16;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_INT     = 3'd2,
    MODE_STR     = 3'd3,
    MODE_WORD    = 3'd4,
    MODE_ERR     = 3'd5
  } mode_t;

  // record kinds
  localparam logic [1:0] REC_CONTENT = 2'd0;
  localparam logic [1:0] REC_END     = 2'd1;
  localparam logic [1:0] REC_EOS     = 2'd2;

  // token kinds
  localparam logic [1:0] TOK_INT  = 2'd0;
  localparam logic [1:0] TOK_STR  = 2'd1;
  localparam logic [1:0] TOK_WORD = 2'd2;
  localparam logic [1:0] TOK_NONE = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_DIGIT   = 2'd1;
  localparam logic [1:0] ERR_OPENSTR = 2'd2;

  // characters
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_BAR  = 8'h7C;
  localparam logic [7:0] CH_UNDR = 8'h5F;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_NUL  = 8'h00;

  // one result record
  typedef struct packed {
    logic [1:0]         record_kind;
    logic [1:0]         token_kind;
    logic [7:0]         content_byte;
    logic [1:0]         error_status;
    logic [FIELD_W-1:0] token_line;
    logic [FIELD_W-1:0] token_column;
    logic [FIELD_W-1:0] token_length;
  } rec_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

endpackage

// File: rtl/command_text_tokenizer.sv
// ----------------------------------------------------------------------------
// command_text_tokenizer: byte-stream tokenizer for command text
// Splits text into integers, bar strings and words, with line/column info.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one source byte per
//   transaction, or an end-of-source mark (in_source_end, or a zero byte).
//   Output channel (out_valid / out_stall) carries result records: content
//   bytes, token end records with kind, length, line and column, and an end
//   of source record with the final error status.
//   Each byte yields zero, one or two records. The byte is held in an input
//   register, decoded there against the scanner state, and its records are
//   written into a four-entry result queue, whose oldest record drives the
//   output, where the receiver takes it when out_stall is low.
//   Throughput: one byte per cycle while the receiver keeps up; the output
//   drains one record per cycle, so a byte that gives two records (the final
//   token end plus end of source) sends them one after the other through the
//   single output port of the result queue.
//   The decode stage waits until the queue has room for two records; while
//   the receiver stalls, the queue fills and in_stall rises.
//   Reset (rst_n low, synchronous) empties the queue and input register and
//   sets line and column to 1, length to 0 and the scanner to idle.
// ----------------------------------------------------------------------------
module command_text_tokenizer #(
  parameter int COUNTER_BITS = cttok_pkg::CNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_text_byte,
  input  logic                          in_source_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_record_kind,
  output logic [1:0]                    out_token_kind,
  output logic [7:0]                    out_content_byte,
  output logic [1:0]                    out_error_status,
  output logic [cttok_pkg::FIELD_W-1:0] out_token_line,
  output logic [cttok_pkg::FIELD_W-1:0] out_token_column,
  output logic [cttok_pkg::FIELD_W-1:0] out_token_length
);
  import cttok_pkg::*;

  // counters are no wider than the output fields; all ones is the ceiling
  localparam int CW = (COUNTER_BITS < FIELD_W) ? COUNTER_BITS : FIELD_W;
  localparam int QDEPTH = 4;
  localparam int QPW = $clog2(QDEPTH);
  localparam logic [QPW:0] QFULL = (QPW+1)'(QDEPTH);
  localparam logic [QPW:0] QROOM2 = (QPW+1)'(QDEPTH - 2);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + CNT_ONE;
  endfunction

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       s1_go;
  logic       in_acc;

  // scanner state
  mode_t         mode_r, mode_nxt;
  logic [CW-1:0] line_r, line_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // result queue
  rec_t           q_mem_r [QDEPTH];
  logic [QPW-1:0] q_wp_r, q_rp_r;
  logic [QPW:0]   q_cnt_r, q_cnt_nxt;
  logic           q_pop;

  // decode outputs
  rec_t       rec0, rec1;
  logic [1:0] n_rec;
  logic       s1_eos;

  assign in_acc   = in_valid && !in_stall;
  assign s1_go    = s1_valid_r && (q_cnt_r <= QROOM2);
  assign in_stall = s1_valid_r && !s1_go;
  assign s1_eos   = s1_end_r || (s1_byte_r == CH_NUL);

  // input stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_acc) begin
      s1_byte_r <= in_text_byte;
      s1_end_r  <= in_source_end;
    end
  end

  // decode: records and next scanner state for the held byte
  always_comb begin
    logic [7:0]    b;
    logic          nl;
    logic          fall;
    logic [CW-1:0] col_adv;
    logic [CW-1:0] scol;
    logic [CW-1:0] cnt_base;
    logic [1:0]    n;
    rec_t          rx;

    b        = s1_byte_r;
    nl       = (b == CH_NL);
    col_adv  = nl ? CNT_ONE : sat_inc(col_r);
    scol     = (cnt_r >= col_r) ? CNT_ONE : col_r - cnt_r;
    cnt_base = '0;
    fall     = 1'b0;
    n        = 2'd0;
    rec0     = '0;
    rec1     = '0;
    rx       = '0;
    mode_nxt = mode_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    cnt_nxt  = cnt_r;

    if (s1_eos) begin
      // end of source: flush a pending integer or word, then the closing record
      rx = '0;
      rx.record_kind  = REC_EOS;
      rx.token_kind   = TOK_NONE;
      rx.error_status = (mode_r == MODE_ERR) ? ERR_DIGIT :
                        (mode_r == MODE_STR) ? ERR_OPENSTR : ERR_OK;
      rx.token_line   = FIELD_W'(line_r);
      rx.token_column = FIELD_W'(col_r);
      if (mode_r == MODE_INT || mode_r == MODE_WORD) begin
        rec0.record_kind  = REC_END;
        rec0.token_kind   = (mode_r == MODE_INT) ? TOK_INT : TOK_WORD;
        rec0.token_line   = FIELD_W'(line_r);
        rec0.token_column = FIELD_W'(scol);
        rec0.token_length = FIELD_W'(cnt_r);
        rec1 = rx;
        n    = 2'd2;
      end else begin
        rec0 = rx;
        n    = 2'd1;
      end
      mode_nxt = MODE_IDLE;
      line_nxt = CNT_ONE;
      col_nxt  = CNT_ONE;
      cnt_nxt  = '0;
    end else begin
      case (mode_r)
        MODE_ERR: begin
          // ignore everything until end of source
        end
        MODE_COMMENT: begin
          col_nxt = col_adv;
          if (nl) begin
            line_nxt = sat_inc(line_r);
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_STR: begin
          col_nxt = col_adv;
          if (nl) line_nxt = sat_inc(line_r);
          if (b == CH_BAR) begin
            // column is taken after the closing bar
            rec0.record_kind  = REC_END;
            rec0.token_kind   = TOK_STR;
            rec0.token_line   = FIELD_W'(line_r);
            rec0.token_column = FIELD_W'((cnt_r >= col_adv) ? CNT_ONE : col_adv - cnt_r);
            rec0.token_length = FIELD_W'(cnt_r);
            cnt_nxt  = '0;
            mode_nxt = MODE_IDLE;
          end else begin
            rec0.record_kind  = REC_CONTENT;
            rec0.token_kind   = TOK_STR;
            rec0.content_byte = b;
            cnt_nxt = sat_inc(cnt_r);
          end
          n = 2'd1;
        end
        MODE_INT: begin
          n = 2'd1;
          if (is_digit(b)) begin
            rec0.record_kind  = REC_CONTENT;
            rec0.token_kind   = TOK_INT;
            rec0.content_byte = b;
            cnt_nxt = sat_inc(cnt_r);
            col_nxt = col_adv;
          end else if (is_alpha(b)) begin
            // digit run followed by a letter: sticky error, no advance
            rec0.record_kind  = REC_END;
            rec0.token_kind   = TOK_INT;
            rec0.error_status = ERR_DIGIT;
            rec0.token_line   = FIELD_W'(line_r);
            rec0.token_column = FIELD_W'(col_r);
            rec0.token_length = FIELD_W'(cnt_r);
            cnt_nxt  = '0;
            mode_nxt = MODE_ERR;
          end else begin
            rec0.record_kind  = REC_END;
            rec0.token_kind   = TOK_INT;
            rec0.token_line   = FIELD_W'(line_r);
            rec0.token_column = FIELD_W'(scol);
            rec0.token_length = FIELD_W'(cnt_r);
            fall = 1'b1;
          end
        end
        MODE_WORD: begin
          n = 2'd1;
          if (is_alpha(b) || is_digit(b) || b == CH_UNDR) begin
            rec0.record_kind  = REC_CONTENT;
            rec0.token_kind   = TOK_WORD;
            rec0.content_byte = b;
            cnt_nxt = sat_inc(cnt_r);
            col_nxt = col_adv;
          end else begin
            rec0.record_kind  = REC_END;
            rec0.token_kind   = TOK_WORD;
            rec0.token_line   = FIELD_W'(line_r);
            rec0.token_column = FIELD_W'(scol);
            rec0.token_length = FIELD_W'(cnt_r);
            fall = 1'b1;
          end
        end
        default: begin
          fall = 1'b1;
        end
      endcase

      // between tokens; also the delimiter that ended a token
      if (fall) begin
        cnt_base = (n != 2'd0) ? '0 : cnt_r;
        cnt_nxt  = cnt_base;
        mode_nxt = MODE_IDLE;
        rx = '0;
        if (b == CH_HASH) begin
          mode_nxt = MODE_COMMENT;
        end else if (is_digit(b)) begin
          rx.record_kind  = REC_CONTENT;
          rx.token_kind   = TOK_INT;
          rx.content_byte = b;
          cnt_nxt  = CNT_ONE;
          mode_nxt = MODE_INT;
        end else if (b == CH_BAR) begin
          cnt_nxt  = '0;
          mode_nxt = MODE_STR;
        end else if (is_alpha(b)) begin
          rx.record_kind  = REC_CONTENT;
          rx.token_kind   = TOK_WORD;
          rx.content_byte = b;
          cnt_nxt  = CNT_ONE;
          mode_nxt = MODE_WORD;
        end
        if (is_digit(b) || is_alpha(b)) begin
          if (n == 2'd0) rec0 = rx;
          else           rec1 = rx;
          n = n + 2'd1;
        end
        col_nxt = col_adv;
        if (nl) line_nxt = sat_inc(line_r);
      end
    end
    n_rec = n;
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      line_r <= CNT_ONE;
      col_r  <= CNT_ONE;
      cnt_r  <= '0;
    end else if (s1_go) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // result queue
  assign q_pop     = out_valid && !out_stall;
  assign q_cnt_nxt = q_cnt_r + (s1_go ? (QPW+1)'(n_rec) : '0) - (QPW+1)'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (q_pop) q_rp_r <= q_rp_r + QPW'(1);
      if (s1_go) q_wp_r <= q_wp_r + QPW'(n_rec);
    end
    if (s1_go && n_rec != 2'd0) q_mem_r[q_wp_r] <= rec0;
    if (s1_go && n_rec == 2'd2) q_mem_r[q_wp_r + QPW'(1)] <= rec1;
  end

  // output ports
  assign out_valid        = (q_cnt_r != '0);
  assign out_record_kind  = q_mem_r[q_rp_r].record_kind;
  assign out_token_kind   = q_mem_r[q_rp_r].token_kind;
  assign out_content_byte = q_mem_r[q_rp_r].content_byte;
  assign out_error_status = q_mem_r[q_rp_r].error_status;
  assign out_token_line   = q_mem_r[q_rp_r].token_line;
  assign out_token_column = q_mem_r[q_rp_r].token_column;
  assign out_token_length = q_mem_r[q_rp_r].token_length;

  // checks
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QFULL)
    else $error("result queue overfilled");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("stall with empty input register");

  a_eos_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_eos) |=> (mode_r == MODE_IDLE && line_r == CNT_ONE &&
                           col_r == CNT_ONE && cnt_r == '0))
    else $error("scanner not cleared after end of source");

  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !s1_eos && mode_r == MODE_ERR) |-> (n_rec == 2'd0))
    else $error("record emitted in error mode");

  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |-> (q_cnt_r + (QPW+1)'(n_rec) <= QFULL))
    else $error("queue written without room");

endmodule

// File: sim/tok_record_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tok_record_checker: record predictor and scoreboard for the tokenizer
// Watches both channels. Each accepted source byte is run through a local
// scanner that queues the records the tokenizer must emit. Each accepted
// output record is compared field by field with the oldest queued record.
// ----------------------------------------------------------------------------
module tok_record_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    in_text_byte,
  input  logic                          in_source_end,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [1:0]                    out_record_kind,
  input  logic [1:0]                    out_token_kind,
  input  logic [7:0]                    out_content_byte,
  input  logic [1:0]                    out_error_status,
  input  logic [cttok_pkg::FIELD_W-1:0] out_token_line,
  input  logic [cttok_pkg::FIELD_W-1:0] out_token_column,
  input  logic [cttok_pkg::FIELD_W-1:0] out_token_length,
  output int                            fail_count,
  output int                            open_records
);
  import cttok_pkg::*;

  // counters are 16 bits wide, so they stop at all ones
  localparam logic [FIELD_W-1:0] CNT_TOP = 16'hFFFF;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LZ   = 8'h7A;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UZ   = 8'h5A;

  // local scanner state
  mode_t              scan_state;
  logic [FIELD_W-1:0] line_no;
  logic [FIELD_W-1:0] col_no;
  logic [FIELD_W-1:0] tok_len;

  // records still owed by the tokenizer
  rec_t record_q[$];
  int   rec_index;

  function automatic logic [FIELD_W-1:0] bump(input logic [FIELD_W-1:0] v);
    return (v == CNT_TOP) ? v : v + 1'b1;
  endfunction

  function automatic bit digit_ch(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic bit letter_ch(input logic [7:0] b);
    return ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ));
  endfunction

  // column where the current token began, clamped at 1
  function automatic logic [FIELD_W-1:0] first_column();
    return (tok_len >= col_no) ? 16'd1 : col_no - tok_len;
  endfunction

  task automatic clear_scan();
    scan_state = MODE_IDLE;
    line_no    = 16'd1;
    col_no     = 16'd1;
    tok_len    = 16'd0;
  endtask

  task automatic move_on(input logic [7:0] b);
    if (b == CH_NL) begin
      line_no = bump(line_no);
      col_no  = 16'd1;
    end else begin
      col_no = bump(col_no);
    end
  endtask

  task automatic queue_rec(input logic [1:0] rk, input logic [1:0] tk,
                           input logic [7:0] cb, input logic [1:0] err,
                           input logic [FIELD_W-1:0] ln,
                           input logic [FIELD_W-1:0] cl,
                           input logic [FIELD_W-1:0] len);
    rec_t r;
    r.record_kind  = rk;
    r.token_kind   = tk;
    r.content_byte = cb;
    r.error_status = err;
    r.token_line   = ln;
    r.token_column = cl;
    r.token_length = len;
    record_q.push_back(r);
  endtask

  task automatic queue_content(input logic [1:0] tk, input logic [7:0] b);
    queue_rec(REC_CONTENT, tk, b, ERR_OK, '0, '0, '0);
  endtask

  // one source byte through the scanner
  task automatic scan_byte(input logic [7:0] b, input logic src_end);
    logic [1:0] err;
    bit         reopen;
    reopen = 1'b0;

    // end of source: flush a pending integer or word, then the final record
    if (src_end || b == CH_NUL) begin
      err = ERR_OK;
      if (scan_state == MODE_INT || scan_state == MODE_WORD)
        queue_rec(REC_END, (scan_state == MODE_INT) ? TOK_INT : TOK_WORD, 8'd0, ERR_OK,
                  line_no, first_column(), tok_len);
      if (scan_state == MODE_ERR)
        err = ERR_DIGIT;
      else if (scan_state == MODE_STR)
        err = ERR_OPENSTR;
      queue_rec(REC_EOS, TOK_NONE, 8'd0, err, line_no, col_no, '0);
      clear_scan();
      return;
    end

    case (scan_state)
      MODE_ERR: ;
      MODE_COMMENT: begin
        move_on(b);
        if (b == CH_NL)
          scan_state = MODE_IDLE;
      end
      MODE_STR: begin
        if (b == CH_BAR) begin
          move_on(b);
          queue_rec(REC_END, TOK_STR, 8'd0, ERR_OK, line_no, first_column(), tok_len);
          tok_len    = '0;
          scan_state = MODE_IDLE;
        end else begin
          queue_content(TOK_STR, b);
          tok_len = bump(tok_len);
          move_on(b);
        end
      end
      MODE_INT: begin
        if (digit_ch(b)) begin
          queue_content(TOK_INT, b);
          tok_len = bump(tok_len);
          move_on(b);
        end else if (letter_ch(b)) begin
          // digit run runs into a letter: sticky error, position of the letter
          queue_rec(REC_END, TOK_INT, 8'd0, ERR_DIGIT, line_no, col_no, tok_len);
          tok_len    = '0;
          scan_state = MODE_ERR;
        end else begin
          queue_rec(REC_END, TOK_INT, 8'd0, ERR_OK, line_no, first_column(), tok_len);
          tok_len = '0;
          reopen  = 1'b1;
        end
      end
      MODE_WORD: begin
        if (letter_ch(b) || digit_ch(b) || b == CH_UNDR) begin
          queue_content(TOK_WORD, b);
          tok_len = bump(tok_len);
          move_on(b);
        end else begin
          queue_rec(REC_END, TOK_WORD, 8'd0, ERR_OK, line_no, first_column(), tok_len);
          tok_len = '0;
          reopen  = 1'b1;
        end
      end
      default: reopen = 1'b1;
    endcase

    // between tokens; the delimiter may open the next token
    if (reopen) begin
      scan_state = MODE_IDLE;
      if (b == CH_HASH) begin
        scan_state = MODE_COMMENT;
      end else if (digit_ch(b)) begin
        queue_content(TOK_INT, b);
        tok_len    = 16'd1;
        scan_state = MODE_INT;
      end else if (b == CH_BAR) begin
        tok_len    = '0;
        scan_state = MODE_STR;
      end else if (letter_ch(b)) begin
        queue_content(TOK_WORD, b);
        tok_len    = 16'd1;
        scan_state = MODE_WORD;
      end
      move_on(b);
    end
  endtask

  task automatic note_fail(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] got,
                             input logic [FIELD_W-1:0] want);
    if (got !== want)
      note_fail($sformatf("record %0d %s: got %0h, expected %0h",
                          rec_index, name, got, want));
  endtask

  // compare one accepted output transaction with the oldest expectation
  task automatic take_record();
    rec_t want;
    if (record_q.size() == 0) begin
      note_fail($sformatf("record %0d arrived with nothing expected", rec_index));
    end else begin
      want = record_q.pop_front();
      check_field("record_kind",  out_record_kind,  want.record_kind);
      check_field("token_kind",   out_token_kind,   want.token_kind);
      check_field("content_byte", out_content_byte, want.content_byte);
      check_field("error_status", out_error_status, want.error_status);
      check_field("token_line",   out_token_line,   want.token_line);
      check_field("token_column", out_token_column, want.token_column);
      check_field("token_length", out_token_length, want.token_length);
    end
    rec_index++;
  endtask

  initial begin
    fail_count   = 0;
    open_records = 0;
    rec_index    = 0;
    clear_scan();
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      record_q.delete();
    end else begin
      if (out_valid && !out_stall)
        take_record();
      if (in_valid && !in_stall)
        scan_byte(in_text_byte, in_source_end);
    end
    open_records = record_q.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the command text tokenizer
// Feeds a short directed text and then randomly built source text (integers,
// words, bar strings, comments, separators, noise, errors and end marks)
// with random gaps and receiver stalls. The record checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import cttok_pkg::*;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_UA   = 8'h41;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [7:0]         in_text_byte  = 8'd0;
  logic               in_source_end = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [1:0]         out_record_kind;
  logic [1:0]         out_token_kind;
  logic [7:0]         out_content_byte;
  logic [1:0]         out_error_status;
  logic [FIELD_W-1:0] out_token_line;
  logic [FIELD_W-1:0] out_token_column;
  logic [FIELD_W-1:0] out_token_length;

  int fail_count;
  int open_records;
  int sent  = 0;
  bit calm  = 1'b0;

  command_text_tokenizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_source_end    (in_source_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_record_kind  (out_record_kind),
    .out_token_kind   (out_token_kind),
    .out_content_byte (out_content_byte),
    .out_error_status (out_error_status),
    .out_token_line   (out_token_line),
    .out_token_column (out_token_column),
    .out_token_length (out_token_length)
  );

  tok_record_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_source_end    (in_source_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_record_kind  (out_record_kind),
    .out_token_kind   (out_token_kind),
    .out_content_byte (out_content_byte),
    .out_error_status (out_error_status),
    .out_token_line   (out_token_line),
    .out_token_column (out_token_column),
    .out_token_length (out_token_length),
    .fail_count       (fail_count),
    .open_records     (open_records)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stalls at random, except in the calm stretch
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 19);
  end

  // one input transaction; called and returns at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic src_end);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_text_byte  <= b;
    in_source_end <= src_end;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(51);
    return (r < 26) ? CH_LA + 8'(r) : CH_UA + 8'(r - 26);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(9);
    if (r < 6)
      return rand_letter();
    else if (r < 9)
      return rand_digit();
    return CH_UNDR;
  endfunction

  // whitespace and stray punctuation
  function automatic logic [7:0] rand_sep();
    case ($urandom_range(7))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return CH_NL;
      3:       return 8'h2C;
      4:       return 8'h3B;
      5:       return 8'h28;
      6:       return 8'h29;
      default: return 8'h7E;
    endcase
  endfunction

  // any nonzero byte but the bar, newlines a bit more often
  function automatic logic [7:0] rand_str_byte();
    logic [7:0] b;
    if ($urandom_range(9) == 0)
      return CH_NL;
    do b = 8'($urandom_range(1, 255)); while (b == CH_BAR);
    return b;
  endfunction

  task automatic send_digits(input int n);
    repeat (n) push_byte(rand_digit(), 1'b0);
  endtask

  task automatic send_word();
    push_byte(rand_letter(), 1'b0);
    repeat ($urandom_range(7)) push_byte(rand_word_char(), 1'b0);
  endtask

  task automatic send_string(input bit closed);
    push_byte(CH_BAR, 1'b0);
    repeat ($urandom_range(8)) push_byte(rand_str_byte(), 1'b0);
    if (closed)
      push_byte(CH_BAR, 1'b0);
  endtask

  task automatic send_comment();
    logic [7:0] b;
    push_byte(CH_HASH, 1'b0);
    repeat ($urandom_range(6)) begin
      do b = 8'($urandom_range(1, 255)); while (b == CH_NL);
      push_byte(b, 1'b0);
    end
    push_byte(CH_NL, 1'b0);
  endtask

  // end of source, by the flag with any byte or by a zero byte
  task automatic send_end();
    if ($urandom_range(1))
      push_byte(8'($urandom_range(255)), 1'b1);
    else
      push_byte(CH_NUL, 1'b0);
  endtask

  // what follows an integer or a word: a separator, a string or a comment
  task automatic send_tail();
    case ($urandom_range(3))
      0:       send_string(1'b1);
      1:       send_comment();
      default: push_byte(rand_sep(), 1'b0);
    endcase
  endtask

  // stimulus
  initial begin
    int pick;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: digits and letters at their extremes, a string across a line,
    // a comment, an integer closed by a zero byte
    send_text("09 Az_9|x\ny|#c\n8");
    push_byte(CH_NUL, 1'b0);
    // digit run into a letter, ignored byte, end flag with byte 255
    send_text("5kq");
    push_byte(8'hFF, 1'b1);
    // string cut off by the end of source
    push_byte(CH_BAR, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(CH_NUL, 1'b1);

    // random source text
    while (sent < 1080) begin
      calm = (sent >= 400) && (sent < 600);
      pick = $urandom_range(99);
      if (pick < 22) begin
        send_digits($urandom_range(1, 6));
        send_tail();
      end else if (pick < 42) begin
        send_word();
        send_tail();
      end else if (pick < 54) begin
        send_string(1'b1);
      end else if (pick < 62) begin
        send_comment();
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 3)) push_byte(rand_sep(), 1'b0);
      end else if (pick < 86) begin
        push_byte(8'($urandom_range(1, 255)), 1'b0);
      end else if (pick < 91) begin
        send_end();
      end else if (pick < 94) begin
        send_digits($urandom_range(1, 4));
        push_byte(rand_letter(), 1'b0);
        repeat ($urandom_range(3)) push_byte(8'($urandom_range(1, 255)), 1'b0);
        send_end();
      end else if (pick < 96) begin
        send_string(1'b0);
        send_end();
      end else begin
        repeat ($urandom_range(1, 2)) push_byte(CH_NL, 1'b0);
      end
    end
    send_end();
    in_valid <= 1'b0;
    calm = 1'b0;

    // drain, then wait for stray records before the verdict
    wait (open_records == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // hard limit on the run
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/cttok_pkg.sv
rtl/command_text_tokenizer.sv
sim/tok_record_checker.sv
sim/tb_top.sv
